// ----- hdl/midi_track_event_serializer_macros.svh -----
// Assertion macros shared by the track serializer RTL.
`ifndef MIDI_TRACK_EVENT_SERIALIZER_MACROS_SVH
`define MIDI_TRACK_EVENT_SERIALIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTES_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MTES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/mtes_pkg.sv -----
// Package with the item types, job type and constants of the track serializer.
`default_nettype none
package mtes_pkg;

  localparam int TIME_BITS = 32;
  // Bits of the timestamp that are kept; the input field is 32 bits wide.
  localparam int TS_BITS   = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int DIFF_W    = TS_BITS + 1;
  localparam int VLQ_BITS  = 28;
  localparam int MAX_BYTES = 7;
  localparam int CNT_W     = 3;

  localparam logic       OP_EVENT   = 1'b0;
  localparam logic       OP_END     = 1'b1;
  localparam logic [7:0] VLQ_MASK   = 8'h7f;
  localparam logic [7:0] VLQ_CONT   = 8'h80;
  localparam logic [7:0] META_BYTE  = 8'hff;
  localparam logic [7:0] EOT_BYTE   = 8'h2f;
  localparam logic [VLQ_BITS-1:0] VLQ_MAX = 28'hfffffff;

  typedef struct packed {
    logic        op;
    logic [31:0] timestamp;
    logic [7:0]  event_type;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // All bytes one item produces, first byte in entry 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
  } job_t;

endpackage
`default_nettype wire

// ----- hdl/mtes_front.sv -----
// Front end: accepts items, tracks time and running status, builds byte jobs.
`default_nettype none
module mtes_front
  import mtes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          job_valid,
  input  wire logic     job_ready,
  output job_t          job
);

  logic [7:0]         prev_status_r, prev_status_nxt;
  logic [TS_BITS-1:0] prev_time_r, prev_time_nxt;

  logic [TS_BITS-1:0]  ts;
  logic [DIFF_W-1:0]   diff;
  logic [VLQ_BITS-1:0] delta;
  logic [2:0]          groups;
  logic                need_status;
  logic [CNT_W-1:0]    rest;
  logic [3:0][7:0]     vlq;
  logic                push;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign push      = in_valid && job_ready;

  assign ts   = in_item.timestamp[TS_BITS-1:0];
  assign diff = {1'b0, ts} - {1'b0, prev_time_r};

  always_comb begin
    if (diff[DIFF_W-1]) begin
      delta = '0;
    end else if (diff > DIFF_W'(VLQ_MAX)) begin
      delta = VLQ_MAX;
    end else begin
      delta = VLQ_BITS'(diff[TS_BITS-1:0]);
    end
  end

  always_comb begin
    if (delta[27:21] != 7'd0) begin
      groups = 3'd4;
    end else if (delta[20:14] != 7'd0) begin
      groups = 3'd3;
    end else if (delta[13:7] != 7'd0) begin
      groups = 3'd2;
    end else begin
      groups = 3'd1;
    end
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      vlq[g] = {1'b0, delta[7*g +: 7]} | ((g > 0) ? VLQ_CONT : 8'h00);
    end
  end

  assign need_status = (in_item.event_type != prev_status_r);

  always_comb begin
    job = '0;
    rest = '0;
    if (in_item.op == OP_END) begin
      job.bytes[0] = 8'h00;
      job.bytes[1] = META_BYTE;
      job.bytes[2] = EOT_BYTE;
      job.bytes[3] = 8'h00;
      job.count    = 3'd4;
    end else begin
      job.count = groups + 3'd2 + {2'b00, need_status};
      for (int p = 0; p < MAX_BYTES; p++) begin
        // Delta bytes go most significant group first, then the tail bytes.
        rest = CNT_W'(p) - groups;
        if (CNT_W'(p) < groups) begin
          job.bytes[p] = vlq[2'(groups - 3'd1 - CNT_W'(p))];
        end else if (need_status) begin
          case (rest)
            3'd0:    job.bytes[p] = in_item.event_type;
            3'd1:    job.bytes[p] = in_item.data_first;
            3'd2:    job.bytes[p] = in_item.data_second;
            default: job.bytes[p] = 8'h00;
          endcase
        end else begin
          case (rest)
            3'd0:    job.bytes[p] = in_item.data_first;
            3'd1:    job.bytes[p] = in_item.data_second;
            default: job.bytes[p] = 8'h00;
          endcase
        end
      end
    end
  end

  always_comb begin
    prev_status_nxt = prev_status_r;
    prev_time_nxt   = prev_time_r;
    if (push) begin
      if (in_item.op == OP_END) begin
        prev_status_nxt = '0;
        prev_time_nxt   = '0;
      end else begin
        prev_status_nxt = in_item.event_type;
        prev_time_nxt   = ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_status_r <= '0;
      prev_time_r   <= '0;
    end else begin
      prev_status_r <= prev_status_nxt;
      prev_time_r   <= prev_time_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mtes_queue.sv -----
// Two-entry job queue between the front end and the byte serializer.
`default_nettype none
module mtes_queue
  import mtes_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      head_valid,
  input  wire logic pop,
  output job_t      head_job
);

  job_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] level_r, level_nxt;
  logic       do_push, do_pop;

  assign push_ready = (level_r != 2'd2);
  assign head_valid = (level_r != 2'd0);
  assign head_job   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mtes_back.sv -----
// Back end: walks the head job one byte per cycle into the output register while the output is not stalled.
`default_nettype none
module mtes_back
  import mtes_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             advance;
  logic             is_last;

  assign advance   = head_valid && (!out_valid_r || out_ready);
  assign is_last   = (idx_r == head_job.count - 3'd1);
  assign pop       = advance && is_last;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.out_byte    = head_job.bytes[idx_r];
      out_item_nxt.last_of_run = is_last;
      idx_nxt                  = is_last ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/midi_track_event_serializer.sv -----
// Top level of the MIDI track event serializer.
//
// The in_ channel takes one item per handshake: a channel event (delta time,
// status, two data bytes) or an end-of-track marker. The out_ channel gives
// the track stream one byte per item, with last_of_run set on the final byte
// an input item causes. An event makes 3 to 7 bytes: a 1 to 4 byte delta,
// the status byte only when it changed, and both data bytes. End of track
// makes 00 FF 2F 00 and clears the remembered status and time.
// An accepted item is written into the job queue at its accepting edge, and
// its first byte is then loaded from the queue head into the output register.
// The output side sends one byte per cycle while out_ready does not hold it,
// and that byte serializer sets the sustained rate. A two-entry job queue
// lets the input keep accepting while the output stalls; in_ready drops once
// both entries are in use.
// Synchronous reset clears the remembered status and time to zero and
// empties the queue and the output register.
`default_nettype none
`include "midi_track_event_serializer_macros.svh"
module midi_track_event_serializer
  import mtes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  logic job_valid, job_ready;
  job_t job;
  logic head_valid, pop;
  job_t head_job;

  mtes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  mtes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  mtes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // An accepted item always leaves a job at the head of the queue in the next cycle.
  `MTES_ASSERT_NEXT(a_accept_gives_output, clk, rst_n, in_valid && in_ready, head_valid)
  // A job leaves the queue exactly when its final byte is loaded.
  `MTES_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, out_valid && out_item.last_of_run)
  // While a non-final byte is shown, the rest of its job is still queued.
  `MTES_ASSERT_SAME(a_job_pending, clk, rst_n, out_valid && !out_item.last_of_run,
                    head_valid)

endmodule
`default_nettype wire

// ----- bench/midi_track_event_serializer_tb.sv -----
// Self-checking bench for the MIDI track event serializer: random bursts in, stalls out.
`default_nettype none
module midi_track_event_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtes_pkg::*;

  localparam logic [31:0] DELTA_CEIL      = 32'h0fff_ffff;
  localparam int          RANDOM_ITEMS    = 200;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          HOLD_OFF_CYCLES = 120;
  localparam int          HOLD_OFF_AFTER  = 40;
  localparam int          MAX_PRINTED     = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  midi_track_event_serializer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  in_item_t    pending_items[$];
  out_item_t   expected_bytes[$];
  logic [7:0]  trk_status = 8'h00;
  logic [31:0] trk_time = '0;
  int          error_count = 0;
  int          accepted_count = 0;
  int          byte_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_pattern = 16'hffff;
  logic [3:0]  stall_phase = '0;
  logic        long_hold = 1'b0;
  out_item_t   oldest_byte;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Track bytes one accepted item must produce, in stream order.
  task automatic predict_track_bytes(input in_item_t item);
    logic [7:0]  run_bytes[$];
    logic [31:0] delta;
    logic [7:0]  vlq_byte;
    int          groups;
    out_item_t   next_byte;
    if (item.op == OP_END) begin
      run_bytes.push_back(8'h00);
      run_bytes.push_back(META_BYTE);
      run_bytes.push_back(EOT_BYTE);
      run_bytes.push_back(8'h00);
      trk_status = 8'h00;
      trk_time = '0;
    end else begin
      delta = (item.timestamp > trk_time) ? item.timestamp - trk_time : 32'd0;
      if (delta > DELTA_CEIL) delta = DELTA_CEIL;
      groups = 1;
      while (groups < 4 && (delta >> (7 * groups)) != 0) groups++;
      for (int g = groups - 1; g >= 0; g--) begin
        vlq_byte = 8'(delta >> (7 * g)) & VLQ_MASK;
        if (g > 0) vlq_byte = vlq_byte | VLQ_CONT;
        run_bytes.push_back(vlq_byte);
      end
      if (item.event_type != trk_status) run_bytes.push_back(item.event_type);
      run_bytes.push_back(item.data_first);
      run_bytes.push_back(item.data_second);
      trk_status = item.event_type;
      trk_time = item.timestamp;
    end
    foreach (run_bytes[i]) begin
      next_byte.out_byte = run_bytes[i];
      next_byte.last_of_run = (i == run_bytes.size() - 1);
      expected_bytes.push_back(next_byte);
    end
  endtask

  function automatic in_item_t make_event(input logic [31:0] ts, input logic [7:0] status,
                                          input logic [7:0] d1, input logic [7:0] d2);
    in_item_t item;
    item.op = OP_EVENT;
    item.timestamp = ts;
    item.event_type = status;
    item.data_first = d1;
    item.data_second = d2;
    return item;
  endfunction

  // The block ignores every field but op here, so fill them with junk.
  function automatic in_item_t make_end(input logic [31:0] junk);
    in_item_t item;
    item.op = OP_END;
    item.timestamp = junk;
    item.event_type = junk[7:0];
    item.data_first = junk[15:8];
    item.data_second = junk[23:16];
    return item;
  endfunction

  // Mostly well-formed tracks with nondecreasing time, some backward steps as noise.
  task automatic queue_random_tracks(input int n_items);
    logic [31:0] gen_time;
    logic [31:0] step;
    logic [32:0] next_ts;
    logic [31:0] ts;
    logic [7:0]  gen_status;
    logic [7:0]  status;
    int          in_track;
    int          track_len;
    int          sel;
    gen_time = '0;
    gen_status = 8'h00;
    in_track = 0;
    track_len = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      if (in_track >= track_len) begin
        pending_items.push_back(make_end($urandom));
        gen_time = '0;
        gen_status = 8'h00;
        in_track = 0;
        track_len = $urandom_range(1, 12);
      end else begin
        sel = $urandom_range(0, 15);
        if (sel < 4) step = 32'd0;
        else if (sel < 8) step = $urandom_range(1, 127);
        else if (sel < 10) step = $urandom_range(1, 16383);
        else if (sel < 12) step = $urandom_range(1, 32'h001f_ffff);
        else if (sel < 13) step = $urandom_range(1, DELTA_CEIL);
        else if (sel < 14) step = $urandom;
        else if (sel < 15) step = 32'd0;
        else begin
          case ($urandom_range(0, 7))
            0: step = 32'd127;
            1: step = 32'd128;
            2: step = 32'd16383;
            3: step = 32'd16384;
            4: step = 32'h001f_ffff;
            5: step = 32'h0020_0000;
            6: step = DELTA_CEIL;
            default: step = DELTA_CEIL + 32'd1;
          endcase
        end
        if (sel == 14) begin
          ts = (gen_time == 0) ? 32'd0 : $urandom_range(0, gen_time - 1);
        end else begin
          next_ts = {1'b0, gen_time} + {1'b0, step};
          if (next_ts[32]) begin
            // Time would wrap, so close the track and start a new one.
            pending_items.push_back(make_end($urandom));
            trk_len_reset: begin
              gen_status = 8'h00;
              in_track = 0;
              track_len = $urandom_range(1, 12);
            end
            ts = step;
          end else begin
            ts = next_ts[31:0];
          end
        end
        if ($urandom_range(0, 1) == 0) status = gen_status;
        else if ($urandom_range(0, 7) == 0) status = 8'h00;
        else status = $urandom;
        pending_items.push_back(make_event(ts, status, $urandom, $urandom));
        gen_time = ts;
        gen_status = status;
        in_track++;
      end
    end
    pending_items.push_back(make_end($urandom));
  endtask

  // Driver: presents items from the pending queue in bursts with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_track_bytes(in_item);
        accepted_count++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0 && !long_hold) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted byte and drives out_ready from a rolling pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("byte %0d: unexpected %02h", byte_count, out_item.out_byte));
        end else begin
          oldest_byte = expected_bytes.pop_front();
          if (out_item.out_byte !== oldest_byte.out_byte)
            flag_error($sformatf("byte %0d: out_byte %02h, wanted %02h", byte_count,
                                 out_item.out_byte, oldest_byte.out_byte));
          if (out_item.last_of_run !== oldest_byte.last_of_run)
            flag_error($sformatf("byte %0d: last_of_run %b, wanted %b", byte_count,
                                 out_item.last_of_run, oldest_byte.last_of_run));
        end
        byte_count++;
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else begin
        if (stall_phase == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = 16'hffff;
            1: stall_pattern = $urandom;
            2: stall_pattern = $urandom | $urandom;
            default: stall_pattern = $urandom & $urandom;
          endcase
        end
        out_ready <= stall_pattern[stall_phase];
        stall_phase = stall_phase + 4'd1;
      end
    end
  end

  // Long receiver hold-off once traffic is flowing, so the job queue fills up.
  initial begin
    wait (accepted_count >= HOLD_OFF_AFTER);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    // Status zero right after reset, then the delta-length boundaries.
    pending_items.push_back(make_event(32'h0000_0000, 8'h00, 8'h00, 8'h00));
    pending_items.push_back(make_event(32'h0000_007f, 8'h90, 8'h3c, 8'h64));
    pending_items.push_back(make_event(32'h0000_0080, 8'h90, 8'h3c, 8'h00));
    pending_items.push_back(make_event(32'h0000_0100, 8'h90, 8'hff, 8'h80));
    pending_items.push_back(make_event(32'h0000_40ff, 8'h80, 8'h7f, 8'h7f));
    pending_items.push_back(make_event(32'h0000_80ff, 8'h80, 8'h00, 8'h01));
    pending_items.push_back(make_event(32'h0020_80fe, 8'hb3, 8'h07, 8'h7f));
    pending_items.push_back(make_event(32'h0040_80fe, 8'hb3, 8'h07, 8'h00));
    pending_items.push_back(make_event(32'h1040_80fd, 8'he0, 8'h00, 8'h40));
    // Delta two past the largest quantity saturates.
    pending_items.push_back(make_event(32'h2040_80fe, 8'he0, 8'h55, 8'haa));
    // Time going backwards gives a zero delta.
    pending_items.push_back(make_event(32'h1000_0000, 8'hff, 8'hff, 8'hff));
    pending_items.push_back(make_event(32'h1000_0000, 8'h00, 8'h80, 8'h80));
    pending_items.push_back(make_end(32'hffff_ffff));
    // Status zero after end of track, with the largest timestamp.
    pending_items.push_back(make_event(32'hffff_ffff, 8'h00, 8'h12, 8'h34));
    pending_items.push_back(make_event(32'hffff_ffff, 8'h00, 8'h56, 8'h78));
    pending_items.push_back(make_event(32'hffff_ffff, 8'hf0, 8'haa, 8'h55));
    pending_items.push_back(make_end(32'h0000_0000));
    pending_items.push_back(make_end(32'h5a5a_a5a5));
    pending_items.push_back(make_event(32'h1000_0000, 8'hc5, 8'h01, 8'h02));
    pending_items.push_back(make_end(32'ha5a5_5a5a));
    queue_random_tracks(RANDOM_ITEMS);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      flag_error($sformatf("%0d bytes never arrived", expected_bytes.size()));

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- midi_track_event_serializer.f -----
+incdir+hdl
hdl/mtes_pkg.sv
hdl/mtes_front.sv
hdl/mtes_queue.sv
hdl/mtes_back.sv
hdl/midi_track_event_serializer.sv
bench/midi_track_event_serializer_tb.sv
